FILE: hdl/hwfb_pkg.sv
// Shared constants, types and the Hamming coefficient ROM for the windowed frame buffer.
package hwfb_pkg;

  localparam int WINDOW_LEN  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int ADDR_BITS   = $clog2(WINDOW_LEN);
  localparam int INDEX_BITS  = 8;
  localparam int HOP_BITS    = 9;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam int HALF_ROM   = 128;
  localparam longint unsigned MICRO_ONE = 64'd1000000;
  localparam longint unsigned MICRO_HALF = 64'd500000;

  // signed coefficient is one bit wider than the unsigned ROM word
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
  localparam int RND_BITS  = PROD_BITS + 1;
  localparam int Q_BITS    = RND_BITS - (COEF_BITS - 1);

  localparam logic signed [RND_BITS-1:0] ROUND_HALF = RND_BITS'(64'd1 << (COEF_BITS - 2));
  localparam logic signed [Q_BITS-1:0] Q_MAX = Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] Q_MIN = Q_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam logic [HOP_BITS-1:0] HOP_LENGTH_RESET = HOP_BITS'(128);

  // register map (index = byte address / 4)
  localparam logic [0:0] REG_HOP_LENGTH = 1'b0;

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_FETCH = 1'b1
  } action_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
    logic                  ready;
  } hwfb_meta_t;

  typedef logic [COEF_BITS-1:0] coef_rom_t [WINDOW_LEN];

  // first half of the symmetric 256-point Hamming window, in millionths
  localparam logic [19:0] HAM_MICRO [HALF_ROM] = '{
    20'd80000,  20'd80140,  20'd80558,  20'd81256,  20'd82232,  20'd83487,  20'd85018,
    20'd86825,  20'd88908,  20'd91264,  20'd93893,  20'd96793,  20'd99962,  20'd103398,
    20'd107099, 20'd111063, 20'd115287, 20'd119769, 20'd124506, 20'd129496, 20'd134734,
    20'd140219, 20'd145946, 20'd151913, 20'd158115, 20'd164549, 20'd171211, 20'd178097,
    20'd185203, 20'd192524, 20'd200056, 20'd207794, 20'd215734, 20'd223871, 20'd232200,
    20'd240716, 20'd249413, 20'd258287, 20'd267332, 20'd276542, 20'd285912, 20'd295437,
    20'd305110, 20'd314925, 20'd324878, 20'd334960, 20'd345168, 20'd355493, 20'd365931,
    20'd376474, 20'd387117, 20'd397852, 20'd408674, 20'd419575, 20'd430550, 20'd441591,
    20'd452691, 20'd463845, 20'd475045, 20'd486285, 20'd497557, 20'd508854, 20'd520171,
    20'd531500, 20'd542834, 20'd554166, 20'd565489, 20'd576797, 20'd588083, 20'd599340,
    20'd610560, 20'd621738, 20'd632866, 20'd643938, 20'd654946, 20'd665885, 20'd676747,
    20'd687527, 20'd698217, 20'd708810, 20'd719302, 20'd729684, 20'd739951, 20'd750097,
    20'd760115, 20'd770000, 20'd779745, 20'd789345, 20'd798793, 20'd808084, 20'd817212,
    20'd826172, 20'd834958, 20'd843565, 20'd851988, 20'd860222, 20'd868261, 20'd876100,
    20'd883736, 20'd891163, 20'd898377, 20'd905373, 20'd912148, 20'd918696, 20'd925015,
    20'd931100, 20'd936947, 20'd942554, 20'd947916, 20'd953030, 20'd957894, 20'd962504,
    20'd966858, 20'd970952, 20'd974785, 20'd978353, 20'd981656, 20'd984690, 20'd987455,
    20'd989948, 20'd992168, 20'd994113, 20'd995782, 20'd997175, 20'd998290, 20'd999128,
    20'd999686, 20'd999965
  };

  // Evaluated at elaboration only: map window position onto the 256-point
  // shape, mirror into the half table, scale to Q1.(COEF_BITS-1) rounding half up.
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t rom;
    longint unsigned j;
    longint unsigned m;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      j = (longint'(i) * 255 + (WINDOW_LEN - 1) / 2) / (WINDOW_LEN - 1);
      if (j > 255) j = 255;
      m = longint'(HAM_MICRO[7'((j < 128) ? j : 255 - j)]);
      rom[i] = COEF_BITS'((m * (64'd1 << (COEF_BITS - 1)) + MICRO_HALF) / MICRO_ONE);
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

FILE: hdl/hwfb_req_if.sv
// Request channel: push a sample or fetch the next windowed element.
interface hwfb_req_if import hwfb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  action_t                       action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source(output valid, action, sample, input ready);
  modport sink(input valid, action, sample, output ready);
endinterface

FILE: hdl/hwfb_rsp_if.sv
// Response channel: one result word per request word.
interface hwfb_rsp_if import hwfb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_value;
  logic [INDEX_BITS-1:0]         element_index;
  logic                          last;
  logic                          ready_res;

  modport source(output valid, window_value, element_index, last, ready_res, input ready);
  modport sink(input valid, window_value, element_index, last, ready_res, output ready);
endinterface

FILE: hdl/hamming_windowed_frame_buffer.sv
// Top level of the Hamming-windowed sliding frame buffer.
//
// Every request word is either a push, which stores one signed sample into a
// 256-entry ring memory, or a fetch, which reads the next window element
// (oldest first) and weights it by a Hamming coefficient. The block takes one
// word per clock unless the response side stalls, and returns exactly one
// response word per request, through the ring read, the multiply, and the round
// and saturate into the output register. The single-port ring memory sets the
// rate: it serves one push write or one fetch read per cycle; a stalled response
// side backs up the three stages before it drops ready on the request side. The
// ring needs no clearing pass after reset: a wrap flag plus the write pointer
// tell which entries were ever written, and an unwritten entry reads as zero.
// hop_length (APB byte address 0, reset 128) sets how many pushes go by between
// window-ready events; a value of zero behaves like one. Write it only while
// the block is idle.
module hamming_windowed_frame_buffer import hwfb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  hwfb_req_if.sink                 req,
  hwfb_rsp_if.source               rsp
);

  // configuration
  logic [HOP_BITS-1:0] hop_length;
  logic                cfg_hit;

  // ring control state
  logic [ADDR_BITS-1:0] write_pos;
  logic                 wrapped;
  logic [HOP_BITS-1:0]  hop_count;
  logic                 frame_ready;
  logic [ADDR_BITS-1:0] read_count;

  logic [ADDR_BITS-1:0] write_pos_next;
  logic                 wrapped_next;
  logic [HOP_BITS-1:0]  hop_count_next;
  logic                 frame_ready_next;
  logic [ADDR_BITS-1:0] read_count_next;

  logic [HOP_BITS-1:0]  hop_inc;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 fetch_last;
  logic                 accept;
  logic                 acc_push;
  logic                 acc_fetch;

  // ring memory
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_LEN];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  // stage 1: read data arrives
  logic                 v1;
  logic                 use1;
  logic [COEF_BITS-1:0] coef1;
  hwfb_meta_t           meta1;

  // stage 2: product
  logic                          v2;
  logic signed [PROD_BITS-1:0]   prod2;
  hwfb_meta_t                    meta2;
  logic signed [SAMPLE_BITS-1:0] samp1;

  // stage 3: output register
  logic                          v3;
  logic signed [SAMPLE_BITS-1:0] value3;
  hwfb_meta_t                    meta3;

  logic signed [RND_BITS-1:0]    rnd2;
  logic signed [Q_BITS-1:0]      q2;
  logic signed [SAMPLE_BITS-1:0] sat2;

  logic adv1;
  logic adv2;
  logic adv3;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_BITS-1] == REG_HOP_LENGTH) &&
                   (paddr[APB_ADDR_BITS-2:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_length <= HOP_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      hop_length <= pwdata[HOP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = APB_DATA_BITS'(hop_length);
    end
  end

  // ---------------------------------------------------------------- flow control
  // Each stage advances when it is empty or the stage after it moves on.
  assign adv3      = !v3 || rsp.ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;
  assign accept    = req.valid && req.ready;
  assign acc_push  = accept && (req.action == ACT_PUSH);
  assign acc_fetch = accept && (req.action == ACT_FETCH);

  // ---------------------------------------------------------------- ring control
  assign rd_addr    = write_pos + read_count;
  assign fetch_last = (read_count == ADDR_BITS'(WINDOW_LEN - 1));
  assign hop_inc    = hop_count + 1'b1;

  always_comb begin
    write_pos_next   = write_pos;
    wrapped_next     = wrapped;
    hop_count_next   = hop_count;
    frame_ready_next = frame_ready;
    read_count_next  = read_count;
    if (acc_push) begin
      write_pos_next  = write_pos + 1'b1;
      if (write_pos == ADDR_BITS'(WINDOW_LEN - 1)) begin
        wrapped_next = 1'b1;
      end
      // a push abandons any partial readout
      read_count_next = '0;
      if (hop_inc >= hop_length) begin
        hop_count_next   = '0;
        frame_ready_next = 1'b1;
      end else begin
        hop_count_next = hop_inc;
      end
    end else if (acc_fetch) begin
      if (fetch_last) begin
        read_count_next  = '0;
        frame_ready_next = 1'b0;
      end else begin
        read_count_next = read_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos   <= '0;
      wrapped     <= 1'b0;
      hop_count   <= '0;
      frame_ready <= 1'b0;
      read_count  <= '0;
    end else begin
      write_pos   <= write_pos_next;
      wrapped     <= wrapped_next;
      hop_count   <= hop_count_next;
      frame_ready <= frame_ready_next;
      read_count  <= read_count_next;
    end
  end

  // One access per cycle: write on push, registered read on fetch. The read
  // data holds while stage 1 stalls because no new fetch is accepted then.
  always_ff @(posedge clk) begin
    if (acc_push) begin
      ring[write_pos] <= req.sample;
    end
    if (acc_fetch) begin
      rd_data <= ring[rd_addr];
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // never-written entries read as zero; pushes carry zero through
      use1        <= acc_fetch && (wrapped || (rd_addr < write_pos));
      coef1       <= COEF_ROM[read_count];
      meta1.index <= acc_fetch ? INDEX_BITS'(read_count) : '0;
      meta1.last  <= acc_fetch && fetch_last;
      meta1.ready <= frame_ready_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign samp1 = use1 ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      prod2 <= PROD_BITS'(samp1) * $signed({1'b0, coef1});
      meta2 <= meta1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // round half up, then clamp to the sample range
  assign rnd2 = RND_BITS'(prod2) + ROUND_HALF;
  assign q2   = rnd2[RND_BITS-1:COEF_BITS-1];

  always_comb begin
    if (q2 > Q_MAX) begin
      sat2 = SAMPLE_BITS'(Q_MAX);
    end else if (q2 < Q_MIN) begin
      sat2 = SAMPLE_BITS'(Q_MIN);
    end else begin
      sat2 = q2[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      value3 <= sat2;
      meta3  <= meta2;
    end
  end

  assign rsp.valid         = v3;
  assign rsp.window_value  = value3;
  assign rsp.element_index = meta3.index;
  assign rsp.last          = meta3.last;
  assign rsp.ready_res     = meta3.ready;

endmodule

FILE: hdl/hwfb_checker.sv
// Port-level assertions for the windowed frame buffer, bound to the top level.
module hwfb_checker import hwfb_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic signed [SAMPLE_BITS-1:0] rsp_window_value,
  input logic [INDEX_BITS-1:0]         rsp_element_index,
  input logic                          rsp_last,
  input logic                          rsp_ready_res
);

  // hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_value) &&
      $stable(rsp_element_index) && $stable(rsp_last) && $stable(rsp_ready_res))
    else $error("response word changed while stalled");

  // the final element always clears the ready flag
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_last |-> !rsp_ready_res)
    else $error("ready flag still set on last element");

  // last marks the final window position only
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_last |-> rsp_element_index == INDEX_BITS'(WINDOW_LEN - 1))
    else $error("last flag on wrong element index");

  // drop the response pipe on reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind hamming_windowed_frame_buffer hwfb_checker u_hwfb_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_window_value  (rsp.window_value),
  .rsp_element_index (rsp.element_index),
  .rsp_last          (rsp.last),
  .rsp_ready_res     (rsp.ready_res)
);

FILE: sim/hamming_windowed_frame_buffer_tb.sv
// Self-checking testbench for the Hamming-windowed sliding frame buffer.
module hamming_windowed_frame_buffer_tb import hwfb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_WORDS  = 20;
  localparam int PIPE_LATENCY = 3;

  // One response word as the block should return it.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]         index;
    logic                          last;
    logic                          ready;
  } frame_word_t;

  // Tracks ring contents, hop counter and readout position; predicts each response word.
  class window_scoreboard;
    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_LEN];
    logic [ADDR_BITS-1:0]          wr_pos;
    logic [INDEX_BITS-1:0]         rd_pos;
    logic [HOP_BITS-1:0]           hop_cnt;
    logic [HOP_BITS-1:0]           hop_len;
    bit                            win_ready;
    int unsigned                   ppm [128];
    frame_word_t                   pending_q[$];
    int                            mismatches;
    int                            pushes;
    int                            fetches;
    int                            readouts;
    int                            ready_rises;

    function new();
      ppm = '{
        80000, 80140, 80558, 81256, 82232, 83487, 85018, 86825, 88908, 91264,
        93893, 96793, 99962, 103398, 107099, 111063, 115287, 119769, 124506,
        129496, 134734, 140219, 145946, 151913, 158115, 164549, 171211, 178097,
        185203, 192524, 200056, 207794, 215734, 223871, 232200, 240716, 249413,
        258287, 267332, 276542, 285912, 295437, 305110, 314925, 324878, 334960,
        345168, 355493, 365931, 376474, 387117, 397852, 408674, 419575, 430550,
        441591, 452691, 463845, 475045, 486285, 497557, 508854, 520171, 531500,
        542834, 554166, 565489, 576797, 588083, 599340, 610560, 621738, 632866,
        643938, 654946, 665885, 676747, 687527, 698217, 708810, 719302, 729684,
        739951, 750097, 760115, 770000, 779745, 789345, 798793, 808084, 817212,
        826172, 834958, 843565, 851988, 860222, 868261, 876100, 883736, 891163,
        898377, 905373, 912148, 918696, 925015, 931100, 936947, 942554, 947916,
        953030, 957894, 962504, 966858, 970952, 974785, 978353, 981656, 984690,
        987455, 989948, 992168, 994113, 995782, 997175, 998290, 999128, 999686,
        999965
      };
      foreach (ring[i]) ring[i] = '0;
      wr_pos      = '0;
      rd_pos      = '0;
      hop_cnt     = '0;
      hop_len     = HOP_LENGTH_RESET;
      win_ready   = 1'b0;
      mismatches  = 0;
      pushes      = 0;
      fetches     = 0;
      readouts    = 0;
      ready_rises = 0;
    endfunction

    function void set_hop(logic [HOP_BITS-1:0] v);
      hop_len = v;
    endfunction

    // Map the window position onto the 256-point shape, mirror, scale to Q1.15.
    function longint coef_at(int unsigned pos);
      longint unsigned j;
      longint unsigned m;
      j = (longint'(pos) * 255 + (WINDOW_LEN - 1) / 2) / (WINDOW_LEN - 1);
      if (j > 255) j = 255;
      m = ppm[(j < 128) ? j : 255 - j];
      return longint'(((m << (COEF_BITS - 1)) + 500000) / 1000000);
    endfunction

    // Round half up (floor after adding half), then clamp to the sample range.
    function logic signed [SAMPLE_BITS-1:0] apply_window(logic signed [SAMPLE_BITS-1:0] s,
                                                         longint c);
      longint r;
      longint q;
      r = longint'(s) * c + (longint'(1) << (COEF_BITS - 2));
      q = r >>> (COEF_BITS - 1);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[SAMPLE_BITS-1:0];
    endfunction

    function void note_word(action_t act, logic signed [SAMPLE_BITS-1:0] smp);
      frame_word_t          w;
      logic [ADDR_BITS-1:0] pos;
      if (act == ACT_PUSH) begin
        ring[wr_pos] = smp;
        wr_pos++;
        hop_cnt++;
        if (hop_cnt >= hop_len) begin
          hop_cnt = '0;
          if (!win_ready) ready_rises++;
          win_ready = 1'b1;
        end
        rd_pos  = '0;
        w.value = '0;
        w.index = '0;
        w.last  = 1'b0;
        pushes++;
      end else begin
        pos     = wr_pos + rd_pos;
        w.value = apply_window(ring[pos], coef_at(rd_pos));
        w.index = rd_pos;
        w.last  = (rd_pos == INDEX_BITS'(WINDOW_LEN - 1));
        if (w.last) begin
          win_ready = 1'b0;
          rd_pos    = '0;
          readouts++;
        end else begin
          rd_pos++;
        end
        fetches++;
      end
      w.ready = win_ready;
      pending_q.push_back(w);
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected response word: window_value %0d element_index %0d",
               got.value, got.index);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (got.value !== want.value) begin
        $error("window_value: expected %0d, got %0d", want.value, got.value);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $error("element_index: expected %0d, got %0d", want.index, got.index);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
      if (got.ready !== want.ready) begin
        $error("ready_res: expected %0d, got %0d", want.ready, got.ready);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  hwfb_req_if req_bus();
  hwfb_rsp_if rsp_bus();

  hamming_windowed_frame_buffer i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_bus),
    .rsp     (rsp_bus)
  );

  window_scoreboard sb;
  frame_word_t      seen;
  int               cycles      = 0;
  int               reg_errors  = 0;
  int               words_sent  = 0;
  bit               no_idle     = 1'b0;  // drop all gaps on both sides while set
  bit               hold_req    = 1'b0;  // ask the receiver for one long hold-off

  always #10 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both channels at the edge: note accepted request words first, then
  // check any response word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      sb.note_word(req_bus.action, req_bus.sample);
    end
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      seen.value = rsp_bus.window_value;
      seen.index = rsp_bus.element_index;
      seen.last  = rsp_bus.last;
      seen.ready = rsp_bus.ready_res;
      sb.check_word(seen);
    end
  end

  // Response side: drop ready for a random stall before each word, or hold off for a
  // long stretch once when asked, so the pipeline backs up into the request side.
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Offer one request word after a random gap; return once it is accepted.
  task automatic send_word(input action_t act, input logic signed [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.action <= act;
    req_bus.sample <= smp;
    do @(posedge clk); while (!req_bus.ready);
    words_sent++;
  endtask

  // Bias toward full-scale samples now and then.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Stop offering words and wait until every predicted response has come back.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  // Write hop_length while idle, then read it back.
  task automatic set_hop_length(input logic [HOP_BITS-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HOP_LENGTH, 2'b00};
    pwdata  <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_hop(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[HOP_BITS-1:0] !== value) begin
      $error("hop_length: expected %0d, got %0d", value, prdata[HOP_BITS-1:0]);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A well-formed burst is pushes followed by fetches; one in eight is noise.
  // The opening burst of a phase fills one hop so the ready flag rises, and
  // with full_read it reads the whole window plus a little wrap.
  task automatic run_burst(input bit opening, input bit full_read);
    int n_push;
    int n_fetch;
    if (!opening && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) send_word(action_t'($urandom_range(0, 1)), pick_sample());
      return;
    end
    if (opening || $urandom_range(0, 3) == 0) n_push = (sb.hop_len == 0) ? 1 : sb.hop_len;
    else n_push = $urandom_range(1, 12);
    if (opening && full_read) n_fetch = $urandom_range(WINDOW_LEN, WINDOW_LEN + 2);
    else n_fetch = $urandom_range(1, 16);
    repeat (n_push) send_word(ACT_PUSH, pick_sample());
    repeat (n_fetch) send_word(ACT_FETCH, pick_sample());
  endtask

  initial begin
    logic [HOP_BITS-1:0] phase_hop [4];
    int                  start;
    sb = new();
    phase_hop = '{9'd1, 9'd256, 9'd0, 9'd23};

    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_bus.valid  <= 1'b0;
    req_bus.action <= ACT_PUSH;
    req_bus.sample <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fetch before anything is pushed: readout runs on the all-zero ring.
    send_word(ACT_FETCH, 16'sh0000);
    send_word(ACT_FETCH, 16'shFFFF);
    // Full-scale and alternating-bit samples.
    send_word(ACT_PUSH, 16'sh8000);
    send_word(ACT_PUSH, 16'sh7FFF);
    send_word(ACT_PUSH, 16'sh0000);
    send_word(ACT_PUSH, 16'shFFFF);
    send_word(ACT_PUSH, 16'sh5555);
    send_word(ACT_PUSH, 16'shAAAA);
    // A push in the middle of a readout restarts at the oldest element.
    send_word(ACT_FETCH, 16'sh1234);
    send_word(ACT_FETCH, 16'sh4321);
    send_word(ACT_PUSH, 16'sh0001);
    send_word(ACT_FETCH, 16'sh0000);
    // Hop length zero: every push raises ready.
    set_hop_length(9'd0);
    send_word(ACT_PUSH, 16'sh7FFF);
    send_word(ACT_PUSH, 16'sh8000);
    // Lower the hop length below the running count: next push hits the limit.
    set_hop_length(9'd511);
    repeat (3) send_word(ACT_PUSH, pick_sample());
    set_hop_length(9'd2);
    send_word(ACT_PUSH, pick_sample());
    send_word(ACT_FETCH, pick_sample());

    // Random phases: hop 1 with a full readout, hop 256 (largest of the four), hop 0 with
    // no gaps on either side, hop 23 with a long response hold-off.
    for (int p = 0; p < 4; p++) begin
      set_hop_length(phase_hop[p]);
      no_idle  = (p == 2);
      hold_req = (p == 3);
      start    = words_sent;
      run_burst(1'b1, p == 0);
      while (words_sent - start < PHASE_WORDS) run_burst(1'b0, 1'b0);
    end
    no_idle = 1'b0;

    drain();
    repeat (PIPE_LATENCY + 3) @(posedge clk);

    $display("Covered %0d pushes and %0d fetches, %0d complete window readouts, %0d ready rises.",
             sb.pushes, sb.fetches, sb.readouts, sb.ready_rises);
    $display("Hop lengths 128, 0, 511, 2, 1, 256, 0, 23; one %0d-cycle response hold-off.",
             LONG_HOLD);
    if (sb.mismatches == 0 && reg_errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
